// File: rtl/segment_intersection_macros.svh
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// Check that holds in the same cycle as its trigger.
`define SGINT_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("sgint check failed");

// Check that holds in the cycle after its trigger.
`define SGINT_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sgint check failed");

`endif

// File: rtl/sgint_pkg.sv
package sgint_pkg;

    // Width of each reported intersection coordinate.
    localparam int OUT_BITS = 32;

    // Result transaction: hit, cross_x, cross_y, padded to whole bytes.
    localparam int OUT_TDATA_BITS = 72;

endpackage

// File: rtl/sgint_front.sv
module sgint_front #(
    parameter int CB = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [8*CB-1:0]           in_data,
    output logic                      out_valid,
    output logic                      out_hit,
    output logic [2*CB+1:0]           out_den,
    output logic [3*CB+3:0]           out_mag_x,
    output logic [3*CB+3:0]           out_mag_y,
    output logic                      out_neg_x,
    output logic                      out_neg_y,
    output logic signed [CB-1:0]      out_base_x,
    output logic signed [CB-1:0]      out_base_y
);
    import sgint_pkg::*;

    localparam int W1 = CB + 1;
    localparam int PW = 2 * W1;
    localparam int DW = PW + 1;
    localparam int VW = 3 * W1 + 2;
    localparam int MW = VW - 1;

    logic signed [CB-1:0] f [8];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            f[k] = $signed(in_data[k*CB +: CB]);
        end
    end

    // Valid bits, one per stage.
    logic [6:0] v_reg;

    // Stage 1: deltas.
    logic signed [W1-1:0] dax1_reg, day1_reg, dbx1_reg, dby1_reg, ex1_reg, ey1_reg;
    logic signed [CB-1:0] asx1_reg, asy1_reg;
    // Stage 2: products.
    logic signed [PW-1:0] p_ab2_reg, p_ba2_reg, p_ae2_reg, p_ea2_reg, p_be2_reg, p_eb2_reg;
    logic signed [W1-1:0] dax2_reg, day2_reg;
    logic signed [CB-1:0] asx2_reg, asy2_reg;
    // Stage 3: denominator and numerators.
    logic signed [DW-1:0] d3_reg, sn3_reg, tn3_reg;
    logic signed [W1-1:0] dax3_reg, day3_reg;
    logic signed [CB-1:0] asx3_reg, asy3_reg;
    // Stage 4: sign normalized.
    logic signed [DW-1:0] d4_reg, sn4_reg, tn4_reg;
    logic                 nz4_reg;
    logic signed [W1-1:0] dax4_reg, day4_reg;
    logic signed [CB-1:0] asx4_reg, asy4_reg;
    // Stage 5: hit decision and partial products of t * direction.
    logic                 hit5_reg;
    logic [PW-1:0]        d5_reg;
    logic signed [PW:0]   plx5_reg, phx5_reg, ply5_reg, phy5_reg;
    logic signed [CB-1:0] asx5_reg, asy5_reg;
    // Stage 6: full products.
    logic                 hit6_reg;
    logic [PW-1:0]        d6_reg;
    logic signed [VW-1:0] vx6_reg, vy6_reg;
    logic signed [CB-1:0] asx6_reg, asy6_reg;
    // Stage 7: magnitudes for the divider.
    logic                 hit7_reg;
    logic [PW-1:0]        d7_reg;
    logic [MW-1:0]        mx7_reg, my7_reg;
    logic                 nx7_reg, ny7_reg;
    logic signed [CB-1:0] asx7_reg, asy7_reg;

    logic signed [DW-1:0] d4_next, sn4_next, tn4_next;
    logic signed [VW-1:0] vx6_next, vy6_next;

    always_comb
    begin
        if (d3_reg[DW-1])
        begin
            d4_next  = -d3_reg;
            sn4_next = -sn3_reg;
            tn4_next = -tn3_reg;
        end
        else
        begin
            d4_next  = d3_reg;
            sn4_next = sn3_reg;
            tn4_next = tn3_reg;
        end
        vx6_next = (VW'(phx5_reg) <<< W1) + VW'(plx5_reg);
        vy6_next = (VW'(phy5_reg) <<< W1) + VW'(ply5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax1_reg <= W1'(f[2]) - W1'(f[0]);
            day1_reg <= W1'(f[3]) - W1'(f[1]);
            dbx1_reg <= W1'(f[6]) - W1'(f[4]);
            dby1_reg <= W1'(f[7]) - W1'(f[5]);
            ex1_reg  <= W1'(f[0]) - W1'(f[4]);
            ey1_reg  <= W1'(f[1]) - W1'(f[5]);
            asx1_reg <= f[0];
            asy1_reg <= f[1];

            p_ab2_reg <= dax1_reg * dby1_reg;
            p_ba2_reg <= dbx1_reg * day1_reg;
            p_ae2_reg <= dax1_reg * ey1_reg;
            p_ea2_reg <= day1_reg * ex1_reg;
            p_be2_reg <= dbx1_reg * ey1_reg;
            p_eb2_reg <= dby1_reg * ex1_reg;
            dax2_reg  <= dax1_reg;
            day2_reg  <= day1_reg;
            asx2_reg  <= asx1_reg;
            asy2_reg  <= asy1_reg;

            d3_reg   <= DW'(p_ab2_reg) - DW'(p_ba2_reg);
            sn3_reg  <= DW'(p_ae2_reg) - DW'(p_ea2_reg);
            tn3_reg  <= DW'(p_be2_reg) - DW'(p_eb2_reg);
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            asx3_reg <= asx2_reg;
            asy3_reg <= asy2_reg;

            d4_reg   <= d4_next;
            sn4_reg  <= sn4_next;
            tn4_reg  <= tn4_next;
            nz4_reg  <= (d3_reg != '0);
            dax4_reg <= dax3_reg;
            day4_reg <= day3_reg;
            asx4_reg <= asx3_reg;
            asy4_reg <= asy3_reg;

            hit5_reg <= nz4_reg && !sn4_reg[DW-1] && (sn4_reg <= d4_reg)
                        && !tn4_reg[DW-1] && (tn4_reg <= d4_reg);
            d5_reg   <= d4_reg[PW-1:0];
            plx5_reg <= $signed({1'b0, tn4_reg[W1-1:0]}) * dax4_reg;
            phx5_reg <= $signed({1'b0, tn4_reg[PW-1:W1]}) * dax4_reg;
            ply5_reg <= $signed({1'b0, tn4_reg[W1-1:0]}) * day4_reg;
            phy5_reg <= $signed({1'b0, tn4_reg[PW-1:W1]}) * day4_reg;
            asx5_reg <= asx4_reg;
            asy5_reg <= asy4_reg;

            hit6_reg <= hit5_reg;
            d6_reg   <= d5_reg;
            vx6_reg  <= vx6_next;
            vy6_reg  <= vy6_next;
            asx6_reg <= asx5_reg;
            asy6_reg <= asy5_reg;

            hit7_reg <= hit6_reg;
            d7_reg   <= d6_reg;
            nx7_reg  <= vx6_reg[VW-1];
            ny7_reg  <= vy6_reg[VW-1];
            mx7_reg  <= vx6_reg[VW-1] ? MW'(-vx6_reg) : MW'(vx6_reg);
            my7_reg  <= vy6_reg[VW-1] ? MW'(-vy6_reg) : MW'(vy6_reg);
            asx7_reg <= asx6_reg;
            asy7_reg <= asy6_reg;
        end
    end

    assign out_valid  = v_reg[6];
    assign out_hit    = hit7_reg;
    assign out_den    = d7_reg;
    assign out_mag_x  = mx7_reg;
    assign out_mag_y  = my7_reg;
    assign out_neg_x  = nx7_reg;
    assign out_neg_y  = ny7_reg;
    assign out_base_x = asx7_reg;
    assign out_base_y = asy7_reg;

endmodule

// File: rtl/sgint_div.sv
module sgint_div #(
    parameter int CB = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            in_hit,
    input  logic [2*CB+1:0]                 in_den,
    input  logic [3*CB+3:0]                 in_mag,
    input  logic                            in_neg,
    input  logic signed [CB-1:0]            in_base,
    output logic                            out_valid,
    output logic                            out_hit,
    output logic [sgint_pkg::OUT_BITS-1:0]  out_coord
);
    import sgint_pkg::*;

    localparam int PW = 2 * (CB + 1);
    localparam int MW = 3 * (CB + 1) + 1;
    localparam int QB = CB + 1;
    localparam int SW = CB + 2;

    // One quotient bit per stage, most significant first.
    logic                 v_reg    [QB];
    logic                 hit_reg  [QB];
    logic [PW-1:0]        den_reg  [QB];
    logic [MW-1:0]        rem_reg  [QB];
    logic [QB-1:0]        q_reg    [QB];
    logic                 neg_reg  [QB];
    logic signed [CB-1:0] base_reg [QB];

    for (genvar i = 0; i < QB; i++)
    begin : g_stage
        localparam int SH = QB - 1 - i;
        logic                 vin, hin, nin;
        logic [PW-1:0]        din;
        logic [MW-1:0]        rin, trial, rem_next;
        logic [QB-1:0]        qin, q_next;
        logic signed [CB-1:0] bin;

        if (i == 0)
        begin : g_first
            assign vin = in_valid;
            assign hin = in_hit;
            assign din = in_den;
            assign rin = in_mag;
            assign qin = '0;
            assign nin = in_neg;
            assign bin = in_base;
        end
        else
        begin : g_rest
            assign vin = v_reg[i-1];
            assign hin = hit_reg[i-1];
            assign din = den_reg[i-1];
            assign rin = rem_reg[i-1];
            assign qin = q_reg[i-1];
            assign nin = neg_reg[i-1];
            assign bin = base_reg[i-1];
        end

        always_comb
        begin
            trial    = MW'(din) << SH;
            rem_next = rin;
            q_next   = qin;
            if (rin >= trial)
            begin
                rem_next   = rin - trial;
                q_next[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hit_reg[i]  <= hin;
                den_reg[i]  <= din;
                rem_reg[i]  <= rem_next;
                q_reg[i]    <= q_next;
                neg_reg[i]  <= nin;
                base_reg[i] <= bin;
            end
        end
    end

    // Start point plus the signed quotient, then round toward zero.
    logic signed [SW-1:0]       sq, sum, fixed;
    logic                       rnz;
    logic                       v_out_reg;
    logic                       hit_out_reg;
    logic [OUT_BITS-1:0]        coord_reg;

    always_comb
    begin
        sq    = neg_reg[QB-1] ? -$signed({1'b0, q_reg[QB-1]}) : $signed({1'b0, q_reg[QB-1]});
        sum   = SW'(base_reg[QB-1]) + sq;
        rnz   = (rem_reg[QB-1] != '0);
        fixed = sum;
        if (rnz && !neg_reg[QB-1] && sum[SW-1])
        begin
            fixed = sum + SW'(1);
        end
        else if (rnz && neg_reg[QB-1] && !sum[SW-1] && (sum != '0))
        begin
            fixed = sum - SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out_reg <= 1'b0;
        end
        else if (en)
        begin
            v_out_reg <= v_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_out_reg <= hit_reg[QB-1];
            coord_reg   <= hit_reg[QB-1] ? OUT_BITS'(fixed) : '0;
        end
    end

    assign out_valid = v_out_reg;
    assign out_hit   = hit_out_reg;
    assign out_coord = coord_reg;

endmodule

// File: rtl/segment_intersection.sv
// An accepted input transaction passes the front-end stages, the divider stages and an output register.
// Throughput: one transaction per cycle; the whole pipeline advances together and stalls
// only while a result sits in the output register and m_tready is low.
// The divider is a restoring divider, one quotient bit per stage.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data registers are not reset.
module segment_intersection #(
    parameter int COORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [8*COORD_BITS-1:0]               s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // hit, cross_x, cross_y, then zero padding
    output logic [sgint_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
    import sgint_pkg::*;

    localparam int CB = COORD_BITS;

    logic                 en;
    logic                 f_valid, f_hit, f_neg_x, f_neg_y;
    logic [2*CB+1:0]      f_den;
    logic [3*CB+3:0]      f_mag_x, f_mag_y;
    logic signed [CB-1:0] f_base_x, f_base_y;
    logic                 x_valid, y_valid, x_hit, y_hit;
    logic [OUT_BITS-1:0]  x_coord, y_coord;

    // The pipeline moves whenever the output register is empty or being drained.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Deltas, cross products, range test and the products t * direction.
    sgint_front #(.CB(CB)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .out_valid  (f_valid),
        .out_hit    (f_hit),
        .out_den    (f_den),
        .out_mag_x  (f_mag_x),
        .out_mag_y  (f_mag_y),
        .out_neg_x  (f_neg_x),
        .out_neg_y  (f_neg_y),
        .out_base_x (f_base_x),
        .out_base_y (f_base_y)
    );

    // Two divider lanes, one per coordinate, running in lockstep.
    sgint_div #(.CB(CB)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_hit    (f_hit),
        .in_den    (f_den),
        .in_mag    (f_mag_x),
        .in_neg    (f_neg_x),
        .in_base   (f_base_x),
        .out_valid (x_valid),
        .out_hit   (x_hit),
        .out_coord (x_coord)
    );

    sgint_div #(.CB(CB)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_hit    (f_hit),
        .in_den    (f_den),
        .in_mag    (f_mag_y),
        .in_neg    (f_neg_y),
        .in_base   (f_base_y),
        .out_valid (y_valid),
        .out_hit   (y_hit),
        .out_coord (y_coord)
    );

    assign m_tvalid = x_valid && y_valid;
    assign m_tdata  = {(OUT_TDATA_BITS - 2*OUT_BITS - 1)'(0), y_coord, x_coord, x_hit && y_hit};

endmodule

// File: rtl/sgint_checker.sv
`include "segment_intersection_macros.svh"

module sgint_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [sgint_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
    import sgint_pkg::*;

    // A miss always reports the point as zero.
    `SGINT_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[2*OUT_BITS:1] == '0)
    // The input side stalls exactly when a result waits unclaimed.
    `SGINT_ASSERT_NOW(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready))
    // A waiting result stays offered.
    `SGINT_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    // A waiting result keeps its value.
    `SGINT_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind segment_intersection sgint_checker u_sgint_checker (.*);

// File: sim/segment_intersection_checker.sv
module segment_intersection_checker #(
    parameter int COORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [8*COORD_BITS-1:0]               s_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [sgint_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    output int                                    errors,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                                 hit;
        logic signed [sgint_pkg::OUT_BITS-1:0] cross_x;
        logic signed [sgint_pkg::OUT_BITS-1:0] cross_y;
    } crossing_t;

    crossing_t crossings_due[$];

    // Exact intersection of the two segments in one transaction, with 128-bit intermediates.
    function automatic crossing_t intersect_segments(input logic [8*COORD_BITS-1:0] word);
        logic signed [127:0] pt [8];
        logic signed [127:0] dax, day, dbx, dby, ex, ey, den, s_num, t_num, px, py;
        crossing_t res;
        for (int i = 0; i < 8; i++)
        begin
            pt[i] = $signed(word[COORD_BITS*i +: COORD_BITS]);
        end
        dax = pt[2] - pt[0];
        day = pt[3] - pt[1];
        dbx = pt[6] - pt[4];
        dby = pt[7] - pt[5];
        ex = pt[0] - pt[4];
        ey = pt[1] - pt[5];
        den = dax * dby - dbx * day;
        s_num = dax * ey - day * ex;
        t_num = dbx * ey - dby * ex;
        res = '0;
        if (den == 0)
        begin
            return res;
        end
        if (den < 0)
        begin
            den = -den;
            s_num = -s_num;
            t_num = -t_num;
        end
        if (s_num < 0 || s_num > den || t_num < 0 || t_num > den)
        begin
            return res;
        end
        // Signed division truncates toward zero.
        px = (den * pt[0] + t_num * dax) / den;
        py = (den * pt[1] + t_num * day) / den;
        res.hit = 1'b1;
        res.cross_x = px[sgint_pkg::OUT_BITS-1:0];
        res.cross_y = py[sgint_pkg::OUT_BITS-1:0];
        return res;
    endfunction

    assign pending = crossings_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t want;
        crossing_t got;
        if (!rst_n)
        begin
            errors <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                crossings_due = {crossings_due, intersect_segments(s_tdata)};
            end
            if (m_tvalid && m_tready)
            begin
                got.hit = m_tdata[0];
                got.cross_x = m_tdata[1 +: sgint_pkg::OUT_BITS];
                got.cross_y = m_tdata[1 + sgint_pkg::OUT_BITS +: sgint_pkg::OUT_BITS];
                if (crossings_due.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0b x=%0d y=%0d",
                             $time, got.hit, got.cross_x, got.cross_y);
                    errors <= errors + 1;
                end
                else
                begin
                    want = crossings_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                                 $time, want.hit, want.cross_x, want.cross_y,
                                 got.hit, got.cross_x, got.cross_y);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: sim/segment_intersection_test.sv
module segment_intersection_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 32;
    localparam int STALL_LIMIT = 5000;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    logic [8*COORD_BITS-1:0]              s_tdata = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    // hit, cross_x, cross_y, then zero padding
    logic [sgint_pkg::OUT_TDATA_BITS-1:0] m_tdata;

    int errors;
    int pending;

    // Percent of cycles each side idles in the current phase.
    int sender_idle_pct = 33;
    int receiver_idle_pct = 73;
    // A nonzero request sets the length, in clock cycles, of a receiver hold-off.
    int hold_request = 0;

    always #5 clk = ~clk;

    segment_intersection #(.COORD_BITS(COORD_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    segment_intersection_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    // The receiver: random backpressure, plus a long hold-off when one is requested.
    // The hold-off lets the pipeline fill so that s_tready must drop.
    always @(posedge clk)
    begin
        int hold_left;
        if (hold_request != 0 && hold_left == 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: any stretch without a transaction on either side that runs too long
    // means the block has hung.
    always @(posedge clk)
    begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one segment pair and hold it until the block takes it. s_tready is looked at
    // in mid-cycle, where every input has settled, and the transaction lands on the next edge.
    task automatic offer_segments(input int asx, input int asy, input int aex, input int aey,
                                  input int bsx, input int bsy, input int bex, input int bey);
        logic taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {bey, bex, bsy, bsx, aey, aex, asy, asx};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Random pairs. Most are drawn from a box small enough that the segments often cross;
    // a few use the full coordinate range so every input bit gets exercised.
    task automatic offer_random_pair();
        int c [8];
        int span;
        int center_x;
        int center_y;
        case ($urandom_range(9))
            0, 1:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    c[i] = $urandom;
                end
            end
            2:
            begin
                // Parallel segments: B is A shifted by an offset, so the denominator is zero.
                for (int i = 0; i < 4; i++)
                begin
                    c[i] = $urandom_range(2000) - 1000;
                end
                span = $urandom_range(20) - 10;
                c[4] = c[0] + span;
                c[5] = c[1] - span;
                c[6] = c[2] + span;
                c[7] = c[3] - span;
            end
            default:
            begin
                span = (1 << $urandom_range(30, 2)) - 1;
                center_x = $urandom;
                center_y = $urandom;
                center_x = center_x >>> 2;
                center_y = center_y >>> 2;
                for (int i = 0; i < 8; i += 2)
                begin
                    c[i] = center_x + int'($urandom_range(2 * span)) - span;
                    c[i + 1] = center_y + int'($urandom_range(2 * span)) - span;
                end
            end
        endcase
        offer_segments(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    localparam int MAXC = 32'sh7FFF_FFFF;
    localparam int MINC = 32'sh8000_0000;

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases: a plain crossing, touches at each end of both segments,
        // parallel and overlapping collinear segments, a zero-length segment,
        // near misses, negative points that truncate toward zero, and the extremes.
        offer_segments(0, 0, 10, 10, 0, 10, 10, 0);
        offer_segments(0, 0, 10, 0, 0, -5, 0, 5);
        offer_segments(0, 0, 10, 0, 10, -5, 10, 5);
        offer_segments(0, 0, 10, 0, 5, 0, 5, 7);
        offer_segments(0, 0, 10, 0, 5, -7, 5, 0);
        offer_segments(0, 0, 10, 0, 11, -5, 11, 5);
        offer_segments(0, 0, 10, 0, 5, 1, 5, 7);
        offer_segments(0, 0, 10, 10, 0, 1, 10, 11);
        offer_segments(0, 0, 10, 10, 2, 2, 20, 20);
        offer_segments(3, 3, 3, 3, 0, 0, 10, 10);
        offer_segments(0, 0, 0, 0, 0, 0, 0, 0);
        offer_segments(-1, -1, -4, -2, -3, 0, -2, -3);
        offer_segments(0, 0, -7, -3, -1, -3, -5, 1);
        offer_segments(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
        offer_segments(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC);
        offer_segments(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
        offer_segments(MAXC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC);
        offer_segments(MINC, MINC, MINC, MAXC, MINC, MINC, MAXC, MINC);
        offer_segments(1, MAXC, MAXC, 1, 0, 0, MAXC, MAXC);
        offer_segments(-1, -1, -1, -1, -1, -1, -1, -1);

        // Pause the sender until every result is back.
        wait_until_drained();

        // Phase one: the receiver idles most. A long hold-off partway through backs
        // the pipeline up while the sender keeps offering.
        for (int n = 0; n < 450; n++)
        begin
            if (n == 100)
            begin
                hold_request = 300;
            end
            offer_random_pair();
        end
        wait_until_drained();

        // Phase two: the sender idles most.
        sender_idle_pct = 73;
        receiver_idle_pct = 33;
        for (int n = 0; n < 450; n++)
        begin
            offer_random_pair();
        end

        // Phase three: full rate on both sides.
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        for (int n = 0; n < 450; n++)
        begin
            offer_random_pair();
        end

        wait_until_drained();
        repeat (60) @(posedge clk);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/sgint_pkg.sv
rtl/sgint_front.sv
rtl/sgint_div.sv
rtl/segment_intersection.sv
rtl/sgint_checker.sv
sim/segment_intersection_checker.sv
sim/segment_intersection_test.sv
